[rtl/smtk_pkg.sv]
// Shared constants for the softmax top-k classifier.
// No dependencies.
package smtk_pkg;
    localparam int MAX_CLASSES = 512;
    localparam int ADDR_W      = $clog2(MAX_CLASSES);
    localparam int CNT_W       = 10;
    localparam int TOP_K       = 5;
    localparam int FILL_W      = $clog2(TOP_K + 1);
    localparam int RANK_W      = 3;
    localparam int LOGIT_W     = 16;
    localparam int EXP_W       = 17;
    localparam int SUM_W       = 26;
    localparam int SQ_STEPS    = 16;
    localparam int DIV_STEPS   = 17;
endpackage

[rtl/smtk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smtk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/softmax_top_k_classifier_top.sv]
// Softmax over one set of Q8.8 logits followed by a top-k ranking.
// Depends on smtk_pkg and smtk_ram.
//
// Channel    Ports                                          Handshake
// ---------  ---------------------------------------------  --------------------------
// logit in   start, busy, logit                             start && !busy && !cfg_we
// config     cfg_we, cfg_data (class_count)                 cfg_we && !busy
// result     result_valid, rank, class_index, probability,  one cycle per transaction,
//            last_result                                    no back-pressure
//
// The last logit of a set starts the sequencer: per class the exponential
// (RAM read, operand load, 16 squarings on the one shared 32x32 multiplier,
// then write), then per class the division (read, load, 17 steps of the
// shared restoring divider, then insert), then one cycle per ranked result,
// up to five.
// Reset: class_count becomes 1, the set restarts; the class stores need none.
// The receiver cannot stall; busy stays high until the last result is out.
module softmax_top_k_classifier_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [smtk_pkg::LOGIT_W-1:0] logit,
    input  logic                          cfg_we,
    input  logic [smtk_pkg::CNT_W-1:0]    cfg_data,
    output logic                          result_valid,
    output logic [smtk_pkg::RANK_W-1:0]   rank,
    output logic [smtk_pkg::ADDR_W-1:0]   class_index,
    output logic [smtk_pkg::EXP_W-1:0]    probability,
    output logic                          last_result
);
    typedef enum logic [3:0] {
        S_LOAD, S_ERD, S_EXI, S_EXP, S_EWR, S_DRD, S_DLD, S_DIV, S_INS, S_OUT
    } state_t;

    typedef logic [smtk_pkg::ADDR_W-1:0] addr_t;
    typedef logic [smtk_pkg::EXP_W-1:0]  prob_t;

    state_t                              state_reg;
    logic [smtk_pkg::CNT_W-1:0]          class_count_reg;
    logic [smtk_pkg::CNT_W-1:0]          load_count_reg;
    logic signed [smtk_pkg::LOGIT_W-1:0] max_reg;
    logic [smtk_pkg::SUM_W-1:0]          sum_reg;
    addr_t                               idx_reg;
    logic [4:0]                          step_reg;
    logic [31:0]                         v_reg;
    logic                                xzero_reg;
    logic [smtk_pkg::SUM_W-1:0]          rem_reg;
    prob_t                               quo_reg;
    prob_t                               best_prob_reg [smtk_pkg::TOP_K];
    addr_t                               best_idx_reg  [smtk_pkg::TOP_K];
    logic [smtk_pkg::FILL_W-1:0]         filled_reg;
    logic [smtk_pkg::FILL_W-1:0]         out_reg;

    // Effective set size: zero means one, saturate at the store depth.
    logic [smtk_pkg::CNT_W-1:0] set_n;
    always_comb
    begin
        if (class_count_reg == '0)
            set_n = smtk_pkg::CNT_W'(1);
        else if (class_count_reg > smtk_pkg::CNT_W'(smtk_pkg::MAX_CLASSES))
            set_n = smtk_pkg::CNT_W'(smtk_pkg::MAX_CLASSES);
        else
            set_n = class_count_reg;
    end

    logic [smtk_pkg::CNT_W-1:0] load_eff;
    assign load_eff = (load_count_reg >= set_n) ? '0 : load_count_reg;

    logic accept;
    assign accept = start && (state_reg == S_LOAD);

    logic idx_last;
    assign idx_last = ({1'b0, idx_reg} == set_n - smtk_pkg::CNT_W'(1));

    // Class stores
    logic signed [smtk_pkg::LOGIT_W-1:0] logit_q;
    prob_t                               exp_q;
    prob_t                               exp_val;

    smtk_ram #(.WIDTH(smtk_pkg::LOGIT_W), .DEPTH(smtk_pkg::MAX_CLASSES)) u_logit_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (load_eff[smtk_pkg::ADDR_W-1:0]),
        .wdata (logit),
        .raddr (idx_reg),
        .rdata (logit_q)
    );

    smtk_ram #(.WIDTH(smtk_pkg::EXP_W), .DEPTH(smtk_pkg::MAX_CLASSES)) u_exp_ram (
        .clk   (clk),
        .we    (state_reg == S_EWR),
        .waddr (idx_reg),
        .wdata (exp_val),
        .raddr (idx_reg),
        .rdata (exp_q)
    );

    // Exponential datapath: x = max - logit, v = 1 - x/2^24 squared 16 times.
    logic [15:0] x_val;
    logic [63:0] sq_prod;
    logic [32:0] v_round;
    assign x_val   = 16'(max_reg - logit_q);
    assign sq_prod = v_reg * v_reg;
    assign v_round = {1'b0, v_reg} + 33'(32768);
    assign exp_val = xzero_reg ? prob_t'(65536) : v_round[32:16];

    // Divider: numerator = e*2^16 + sum/2, quotient fits 17 bits.
    logic [33:0] div_num;
    logic [smtk_pkg::SUM_W:0] div_trial;
    logic div_ge;
    assign div_num   = {exp_q, 16'b0} + 34'(sum_reg >> 1);
    assign div_trial = {rem_reg, quo_reg[smtk_pkg::EXP_W-1]};
    assign div_ge    = (div_trial >= {1'b0, sum_reg});

    // Top-k insertion position: count of kept entries not beaten by p.
    prob_t p_val;
    logic [smtk_pkg::FILL_W-1:0] ins_pos;
    assign p_val = (sum_reg == '0) ? '0 : quo_reg;
    always_comb
    begin
        ins_pos = '0;
        for (int j = 0; j < smtk_pkg::TOP_K; j++)
        begin
            if ((smtk_pkg::FILL_W'(j) < filled_reg) && !(p_val > best_prob_reg[j]))
                ins_pos = ins_pos + smtk_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            class_count_reg <= smtk_pkg::CNT_W'(1);
            load_count_reg  <= '0;
            max_reg         <= 16'sh8000;
            sum_reg         <= '0;
            idx_reg         <= '0;
            step_reg        <= '0;
            filled_reg      <= '0;
            out_reg         <= '0;
            xzero_reg       <= 1'b0;
            v_reg           <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            for (int j = 0; j < smtk_pkg::TOP_K; j++)
            begin
                best_prob_reg[j] <= '0;
                best_idx_reg[j]  <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (cfg_we)
                    begin
                        class_count_reg <= cfg_data;
                        load_count_reg  <= '0;
                        max_reg         <= 16'sh8000;
                        sum_reg         <= '0;
                    end
                    else if (accept)
                    begin
                        if (logit > max_reg)
                            max_reg <= logit;
                        load_count_reg <= load_eff + smtk_pkg::CNT_W'(1);
                        if (load_eff + smtk_pkg::CNT_W'(1) >= set_n)
                        begin
                            idx_reg   <= '0;
                            sum_reg   <= '0;
                            state_reg <= S_ERD;
                        end
                    end
                end
                S_ERD:
                    state_reg <= S_EXI;
                S_EXI:
                begin
                    xzero_reg <= (x_val == '0);
                    v_reg     <= 32'(0) - {8'b0, x_val, 8'b0};
                    step_reg  <= '0;
                    state_reg <= S_EXP;
                end
                S_EXP:
                begin
                    v_reg    <= sq_prod[63:32];
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(smtk_pkg::SQ_STEPS - 1))
                        state_reg <= S_EWR;
                end
                S_EWR:
                begin
                    sum_reg <= sum_reg + smtk_pkg::SUM_W'(exp_val);
                    if (idx_last)
                    begin
                        idx_reg    <= '0;
                        filled_reg <= '0;
                        state_reg  <= S_DRD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + addr_t'(1);
                        state_reg <= S_ERD;
                    end
                end
                S_DRD:
                    state_reg <= S_DLD;
                S_DLD:
                begin
                    rem_reg   <= smtk_pkg::SUM_W'(div_num[33:17]);
                    quo_reg   <= div_num[16:0];
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= div_ge ? smtk_pkg::SUM_W'(div_trial - {1'b0, sum_reg})
                                       : smtk_pkg::SUM_W'(div_trial);
                    quo_reg  <= {quo_reg[smtk_pkg::EXP_W-2:0], div_ge};
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(smtk_pkg::DIV_STEPS - 1))
                        state_reg <= S_INS;
                end
                S_INS:
                begin
                    if (ins_pos < smtk_pkg::FILL_W'(smtk_pkg::TOP_K))
                    begin
                        for (int j = 0; j < smtk_pkg::TOP_K; j++)
                        begin
                            if (smtk_pkg::FILL_W'(j) == ins_pos)
                            begin
                                best_prob_reg[j] <= p_val;
                                best_idx_reg[j]  <= idx_reg;
                            end
                            else if ((j > 0) && (smtk_pkg::FILL_W'(j) > ins_pos))
                            begin
                                best_prob_reg[j] <= best_prob_reg[j-1];
                                best_idx_reg[j]  <= best_idx_reg[j-1];
                            end
                        end
                        if (filled_reg < smtk_pkg::FILL_W'(smtk_pkg::TOP_K))
                            filled_reg <= filled_reg + smtk_pkg::FILL_W'(1);
                    end
                    if (idx_last)
                    begin
                        out_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + addr_t'(1);
                        state_reg <= S_DRD;
                    end
                end
                S_OUT:
                begin
                    out_reg <= out_reg + smtk_pkg::FILL_W'(1);
                    if (last_result)
                    begin
                        load_count_reg <= '0;
                        max_reg        <= 16'sh8000;
                        sum_reg        <= '0;
                        state_reg      <= S_LOAD;
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    // Result transaction straight from the ranking registers.
    logic [smtk_pkg::FILL_W-1:0] out_sel;
    assign out_sel = (out_reg < smtk_pkg::FILL_W'(smtk_pkg::TOP_K)) ? out_reg : '0;

    assign busy         = (state_reg != S_LOAD);
    assign result_valid = (state_reg == S_OUT);
    assign rank         = smtk_pkg::RANK_W'(out_reg);
    assign class_index  = best_idx_reg[out_sel];
    assign probability  = best_prob_reg[out_sel];
    assign last_result  = result_valid && (out_reg + smtk_pkg::FILL_W'(1) == filled_reg);

    // Checks
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("result outside busy window");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |=> !busy) else $error("busy after last result");
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |=> result_valid) else $error("result burst broken");
    a_first_rank: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> rank == '0) else $error("burst not starting at rank 0");
endmodule
